>>> sv/lsbc_pkg.sv
package lsbc_pkg;

    localparam int unsigned CodeW   = 4;
    localparam int unsigned TimerW  = 12;
    localparam int unsigned CountW  = 6;
    localparam int unsigned StateW  = 2;
    localparam int unsigned LedW    = 4;
    localparam int unsigned PauseW  = 4;
    localparam int unsigned CfgIdxW = 4;
    localparam int unsigned CfgDatW = 12;

    localparam logic [TimerW-1:0] BlinkPeriodRst  = 12'd3500;
    localparam logic [TimerW-1:0] DarkAfterRst    = 12'd1000;
    localparam logic [TimerW-1:0] BlankTicksRst   = 12'd2500;
    localparam logic [PauseW-1:0] PausePeriodsRst = 4'd5;

    localparam logic [LedW-1:0] LedsOff   = 4'h0;
    localparam logic [LedW-1:0] LedsGreen = 4'h5;
    localparam logic [LedW-1:0] LedsRed   = 4'hA;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BLINK_PERIOD  = 4'd0,
        REG_DARK_AFTER    = 4'd1,
        REG_BLANK_TICKS   = 4'd2,
        REG_PAUSE_PERIODS = 4'd3
    } t_reg_idx;

    typedef enum logic {
        FUNC_TICK   = 1'b0,
        FUNC_REPORT = 1'b1
    } t_func;

    typedef enum logic [StateW-1:0] {
        SYS_OFF  = 2'd0,
        SYS_IDLE = 2'd1,
        SYS_GYRO = 2'd2,
        SYS_SUN  = 2'd3
    } t_sys;

    typedef struct packed {
        logic [TimerW-1:0] blink_period;
        logic [TimerW-1:0] dark_after;
        logic [TimerW-1:0] blank_ticks;
        logic [PauseW-1:0] pause_periods;
    } t_cfg;

    typedef struct packed {
        logic              func;
        logic [CodeW-1:0]  error_code;
        logic [StateW-1:0] system_state;
        logic              angle_bit;
    } t_item;

    typedef struct packed {
        logic [LedW-1:0]  led_pattern;
        logic [CodeW-1:0] active_error;
    } t_res;

endpackage

>>> sv/lsbc_if.sv
interface lsbc_in_if;
    import lsbc_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [CodeW-1:0]  error_code;
    logic [StateW-1:0] system_state;
    logic              angle_bit;
    modport source (output valid, func, error_code, system_state, angle_bit, input ready);
    modport sink   (input valid, func, error_code, system_state, angle_bit, output ready);
endinterface

interface lsbc_out_if;
    import lsbc_pkg::*;
    logic             valid;
    logic             ready;
    logic [LedW-1:0]  led_pattern;
    logic [CodeW-1:0] active_error;
    modport source (output valid, led_pattern, active_error, input ready);
    modport sink   (input valid, led_pattern, active_error, output ready);
endinterface

>>> sv/lsbc_cfg.sv
module lsbc_cfg
    import lsbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [CfgIdxW-1:0] i_index,
    input  logic [CfgDatW-1:0] i_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_period  <= BlinkPeriodRst;
            r_cfg.dark_after    <= DarkAfterRst;
            r_cfg.blank_ticks   <= BlankTicksRst;
            r_cfg.pause_periods <= PausePeriodsRst;
        end else if (i_we) begin
            case (i_index)
                REG_BLINK_PERIOD:  r_cfg.blink_period  <= i_data[TimerW-1:0];
                REG_DARK_AFTER:    r_cfg.dark_after    <= i_data[TimerW-1:0];
                REG_BLANK_TICKS:   r_cfg.blank_ticks   <= i_data[TimerW-1:0];
                REG_PAUSE_PERIODS: r_cfg.pause_periods <= i_data[PauseW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/lsbc_engine.sv
module lsbc_engine
    import lsbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    logic [CodeW-1:0]         r_shown, n_shown;
    logic [CodeW-1:0]         r_pend, n_pend;
    logic [TimerW-1:0]        r_timer, n_timer;
    logic signed [CountW-1:0] r_count, n_count;
    logic [StateW-1:0]        r_prev, n_prev;
    logic [TimerW-1:0]        r_blank, n_blank;
    logic [LedW-1:0]          r_led, n_led;

    logic [TimerW:0]          timer_inc;
    logic signed [CountW-1:0] count_inc;
    logic [TimerW-1:0]        blank_cur;
    logic                     dark;

    always_comb begin
        n_shown   = r_shown;
        n_pend    = r_pend;
        n_timer   = r_timer;
        n_count   = r_count;
        n_prev    = r_prev;
        n_blank   = r_blank;
        n_led     = r_led;
        timer_inc = {1'b0, r_timer} + {{TimerW{1'b0}}, 1'b1};
        count_inc = r_count + CountW'(1);
        blank_cur = r_blank;
        dark      = 1'b0;
        if (i_item.func == FUNC_REPORT) begin
            if (i_item.error_code != '0) begin
                if (r_pend == '0 || i_item.error_code < r_pend) begin
                    n_pend = i_item.error_code;
                end
                if (r_shown == '0 || i_item.error_code < r_shown) begin
                    n_shown = i_item.error_code;
                end
            end
        end else begin
            if (r_shown != '0) begin
                if (timer_inc > {1'b0, i_cfg.blink_period} || timer_inc[TimerW]) begin
                    n_timer = '0;
                    n_count = count_inc;
                    if (count_inc > $signed({{(CountW-CodeW){1'b0}}, r_shown})) begin
                        n_count = -$signed({{(CountW-PauseW){1'b0}}, i_cfg.pause_periods});
                        n_shown = r_pend;
                        n_pend  = '0;
                    end
                end else begin
                    n_timer = timer_inc[TimerW-1:0];
                end
                dark = (n_timer > i_cfg.dark_after) && (n_count > $signed(CountW'(0)));
            end
            if (dark) begin
                n_led = LedsOff;
            end else begin
                if (i_item.system_state != r_prev) begin
                    blank_cur = i_cfg.blank_ticks;
                    n_prev    = i_item.system_state;
                end
                if (blank_cur != '0) begin
                    n_blank = blank_cur - TimerW'(1);
                    n_led   = LedsOff;
                end else begin
                    n_blank = blank_cur;
                    unique case (t_sys'(i_item.system_state))
                        SYS_OFF:  n_led = LedsOff;
                        SYS_IDLE: n_led = LedsGreen;
                        SYS_GYRO: n_led = i_item.angle_bit ? LedsRed : LedsGreen;
                        SYS_SUN:  n_led = r_led;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= '0;
            r_pend  <= '0;
            r_timer <= '0;
            r_count <= '0;
            r_prev  <= '0;
            r_blank <= '0;
            r_led   <= '0;
        end else if (i_step) begin
            r_shown <= n_shown;
            r_pend  <= n_pend;
            r_timer <= n_timer;
            r_count <= n_count;
            r_prev  <= n_prev;
            r_blank <= n_blank;
            r_led   <= n_led;
        end
    end

    assign o_res.led_pattern  = n_led;
    assign o_res.active_error = n_shown;

`ifndef SYNTH
    a_report_sets_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.func == FUNC_REPORT && i_item.error_code != '0 |=> r_shown != '0)
        else $error("report left no active error");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= $signed(CountW'(16)) && r_count >= -$signed(CountW'(15)))
        else $error("blink count out of range");
    a_dark_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && dark |=> r_led == LedsOff && $stable(r_blank))
        else $error("dark blink lit leds or moved blank timer");
    a_idle_error_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.func == FUNC_TICK && r_shown == '0 |=> r_shown == '0 && $stable(r_timer))
        else $error("timer moved without active error");
`endif

endmodule

>>> sv/led_status_blink_code_unit.sv
// channel | dir | handshake     | payload
// i_in    | in  | valid & ready | func, error_code, system_state, angle_bit
// o_out   | out | valid & ready | led_pattern, active_error
// i_cfg_* | in  | i_cfg_we      | i_cfg_index, i_cfg_data
// One item per cycle unless o_out stalls; stages: input register, result register.
// The single-pass update of the blink and blank timers sets this per-cycle rate.
// Synchronous reset on i_rst_n; all registers but r_item and r_res take defaults.
// A stalled result holds; the input register takes an item while it is empty
// or while the result register is free or being drained.
module led_status_blink_code_unit
    import lsbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    lsbc_in_if.sink            i_in,
    lsbc_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgDatW-1:0] i_cfg_data
);

    logic  r_in_valid;
    t_item r_item;
    logic  r_out_valid;
    t_res  r_res;
    t_res  res;
    t_cfg  cfg;
    logic  advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    lsbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lsbc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.func         <= i_in.func;
            r_item.error_code   <= i_in.error_code;
            r_item.system_state <= i_in.system_state;
            r_item.angle_bit    <= i_in.angle_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.led_pattern  = r_res.led_pattern;
    assign o_out.active_error = r_res.active_error;

`ifndef SYNTH
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_out.ready |=> r_in_valid && $stable(r_item))
        else $error("pending item lost during stall");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input not ready while empty");
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result not registered");
`endif

endmodule
